// File: hdl/stei_pkg.sv
package stei_pkg;

	localparam int NORM_BITS = 30;
	localparam int Q_FRAC = 14;
	localparam int QUO_W = 15;
	localparam int ROOT1_N = 31;
	localparam int ROOT2_N = 32;
	localparam int AM_W = 32;
	localparam logic signed [15:0] Q_ONE = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic [NORM_BITS-1:0] dm;
		logic [NORM_BITS-1:0] bm;
		logic dneg;
		logic bneg;
		logic diag;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} front_side_t;

	typedef struct packed {
		logic bneg;
		logic pneg;
		logic pzero;
		logic diag;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
	} out_side_t;

	typedef struct packed {
		logic [AM_W-1:0] am;
		logic [NORM_BITS-1:0] bm;
		out_side_t flags;
	} root_side_t;

	function automatic logic signed [15:0] sign_unit(logic signed [15:0] v);
		logic signed [15:0] u;
		u = 16'sd0;
		if (v > 16'sd0) begin
			u = Q_ONE;
		end else if (v < 16'sd0) begin
			u = -Q_ONE;
		end
		return u;
	endfunction

endpackage

// File: hdl/stei_if.sv
interface stei_pix_if;
	logic valid;
	logic ready;
	logic signed [15:0] grad_x;
	logic signed [15:0] grad_y;
	logic [31:0] tensor_xx;
	logic [31:0] tensor_yy;
	logic signed [31:0] tensor_xy;
	modport source(output valid, grad_x, grad_y, tensor_xx, tensor_yy, tensor_xy, input ready);
	modport sink(input valid, grad_x, grad_y, tensor_xx, tensor_yy, tensor_xy, output ready);
endinterface

interface stei_dir_if;
	logic valid;
	logic ready;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;
	modport source(output valid, dir_x, dir_y, input ready);
	modport sink(input valid, dir_x, dir_y, output ready);
endinterface

// File: hdl/stei_front.sv
module stei_front (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [15:0] grad_x,
	input logic signed [15:0] grad_y,
	input logic [31:0] tensor_xx,
	input logic [31:0] tensor_yy,
	input logic signed [31:0] tensor_xy,
	output logic out_valid,
	output logic [2*stei_pkg::ROOT1_N-1:0] rad,
	output stei_pkg::front_side_t side
);
	import stei_pkg::*;

	logic [32:0] d;
	logic dneg;
	logic bneg;
	logic [31:0] dm;
	logic [31:0] xy_abs;
	logic signed [15:0] dx;
	logic signed [15:0] dy;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [15:0] gx_s1, gx_s2, gx_s3, gx_s4, gx_s5;
	logic signed [15:0] gy_s1, gy_s2, gy_s3, gy_s4, gy_s5;
	logic dneg_s1, dneg_s2, dneg_s3, dneg_s4, dneg_s5;
	logic bneg_s1, bneg_s2, bneg_s3, bneg_s4, bneg_s5;
	logic diag_s1, diag_s2, diag_s3, diag_s4, diag_s5;
	logic signed [15:0] dx_s1, dx_s2, dx_s3, dx_s4, dx_s5;
	logic signed [15:0] dy_s1, dy_s2, dy_s3, dy_s4, dy_s5;
	logic [32:0] dm_s1, dm_s2;
	logic [32:0] bm_s1, bm_s2;
	logic [5:0] len_s2;
	logic [NORM_BITS-1:0] dm_s3, dm_s4, dm_s5;
	logic [NORM_BITS-1:0] bm_s3, bm_s4, bm_s5;
	logic [2*NORM_BITS-1:0] dsq_s4, bsq_s4;
	logic [2*ROOT1_N-1:0] rad_s5;

	logic [32:0] mx;
	logic [5:0] len;
	logic [5:0] sh_r;
	logic [5:0] sh_l;
	logic [32:0] dm_sh;
	logic [32:0] bm_sh;
	logic [NORM_BITS-1:0] bm_fix;

	always_comb begin
		d = {1'b0, tensor_xx} - {1'b0, tensor_yy};
		dneg = d[32];
		dm = dneg ? 32'(-d) : d[31:0];
		bneg = tensor_xy[31];
		xy_abs = bneg ? 32'(-tensor_xy) : 32'(tensor_xy);
		dx = 16'sd0;
		dy = 16'sd0;
		if (tensor_xx == 32'd0 && tensor_yy == 32'd0) begin
			dx = 16'sd0;
		end else if (tensor_xx > tensor_yy) begin
			dx = sign_unit(grad_x);
		end else begin
			dy = sign_unit(grad_y);
		end
	end

	always_comb begin
		mx = (dm_s1 > bm_s1) ? dm_s1 : bm_s1;
		len = 6'd0;
		for (int i = 0; i < 33; i++) begin
			if (mx[i]) begin
				len = 6'(i + 1);
			end
		end
	end

	always_comb begin
		sh_r = len_s2 - 6'(NORM_BITS);
		sh_l = 6'(NORM_BITS) - len_s2;
		if (len_s2 > 6'(NORM_BITS)) begin
			dm_sh = dm_s2 >> sh_r;
			bm_sh = bm_s2 >> sh_r;
		end else begin
			dm_sh = dm_s2 << sh_l;
			bm_sh = bm_s2 << sh_l;
		end
		bm_fix = (bm_sh[NORM_BITS-1:0] == '0) ? NORM_BITS'(1) : bm_sh[NORM_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1 <= grad_x;
			gy_s1 <= grad_y;
			dneg_s1 <= dneg;
			bneg_s1 <= bneg;
			diag_s1 <= (tensor_xy == 32'sd0);
			dx_s1 <= dx;
			dy_s1 <= dy;
			dm_s1 <= {1'b0, dm};
			bm_s1 <= {xy_abs, 1'b0};

			gx_s2 <= gx_s1;
			gy_s2 <= gy_s1;
			dneg_s2 <= dneg_s1;
			bneg_s2 <= bneg_s1;
			diag_s2 <= diag_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dm_s2 <= dm_s1;
			bm_s2 <= bm_s1;
			len_s2 <= len;

			gx_s3 <= gx_s2;
			gy_s3 <= gy_s2;
			dneg_s3 <= dneg_s2;
			bneg_s3 <= bneg_s2;
			diag_s3 <= diag_s2;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			dm_s3 <= dm_sh[NORM_BITS-1:0];
			bm_s3 <= bm_fix;

			gx_s4 <= gx_s3;
			gy_s4 <= gy_s3;
			dneg_s4 <= dneg_s3;
			bneg_s4 <= bneg_s3;
			diag_s4 <= diag_s3;
			dx_s4 <= dx_s3;
			dy_s4 <= dy_s3;
			dm_s4 <= dm_s3;
			bm_s4 <= bm_s3;
			dsq_s4 <= dm_s3 * dm_s3;
			bsq_s4 <= bm_s3 * bm_s3;

			gx_s5 <= gx_s4;
			gy_s5 <= gy_s4;
			dneg_s5 <= dneg_s4;
			bneg_s5 <= bneg_s4;
			diag_s5 <= diag_s4;
			dx_s5 <= dx_s4;
			dy_s5 <= dy_s4;
			dm_s5 <= dm_s4;
			bm_s5 <= bm_s4;
			rad_s5 <= (2*ROOT1_N)'(dsq_s4) + (2*ROOT1_N)'(bsq_s4);
		end
	end

	assign out_valid = v_s5;
	assign rad = rad_s5;
	assign side.gx = gx_s5;
	assign side.gy = gy_s5;
	assign side.dm = dm_s5;
	assign side.bm = bm_s5;
	assign side.dneg = dneg_s5;
	assign side.bneg = bneg_s5;
	assign side.diag = diag_s5;
	assign side.dx = dx_s5;
	assign side.dy = dy_s5;

endmodule

// File: hdl/stei_isqrt.sv
module stei_isqrt #(
	parameter int N = 31,
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [2*N-1:0] rad,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [N-1:0] root,
	output logic [SIDE_W-1:0] side_out
);
	localparam int W = 2 * N;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] res_s [N];
	logic vld_s [N];
	logic [SIDE_W-1:0] side_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - k));
		logic [W-1:0] cur_rem;
		logic [W-1:0] cur_res;
		logic cur_vld;
		logic [SIDE_W-1:0] cur_side;
		logic [W-1:0] trial;

		if (k == 0) begin : g_first
			assign cur_rem = rad;
			assign cur_res = '0;
			assign cur_vld = in_valid;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_rem = rem_s[k-1];
			assign cur_res = res_s[k-1];
			assign cur_vld = vld_s[k-1];
			assign cur_side = side_s[k-1];
		end

		assign trial = cur_res + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= cur_side;
				if (cur_rem >= trial) begin
					rem_s[k] <= cur_rem - trial;
					res_s[k] <= (cur_res >> 1) + BIT;
				end else begin
					rem_s[k] <= cur_rem;
					res_s[k] <= cur_res >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root = res_s[N-1][N-1:0];
	assign side_out = side_s[N-1];

endmodule

// File: hdl/stei_mid.sv
module stei_mid (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [stei_pkg::ROOT1_N-1:0] s,
	input stei_pkg::front_side_t side_in,
	output logic out_valid,
	output logic [2*stei_pkg::ROOT2_N-1:0] rad,
	output stei_pkg::root_side_t side_out
);
	import stei_pkg::*;

	logic v_s1, v_s2, v_s3;
	front_side_t side_s1, side_s2;
	logic [AM_W-1:0] am_s1, am_s2, am_s3;
	logic [NORM_BITS-1:0] bm_s3;
	logic [63:0] asq_s2;
	logic [2*NORM_BITS-1:0] bsq_s2;
	logic signed [48:0] pa_s2;
	logic signed [46:0] pb_s2;
	logic [2*ROOT2_N-1:0] rad_s3;
	out_side_t flags_s3;

	logic [AM_W-1:0] am;
	logic signed [32:0] am_sx;
	logic signed [30:0] bm_sx;
	logic signed [49:0] p;

	always_comb begin
		if (side_in.dneg) begin
			am = AM_W'(s) - AM_W'(side_in.dm);
		end else begin
			am = AM_W'(s) + AM_W'(side_in.dm);
		end
		am_sx = signed'({1'b0, am_s1});
		bm_sx = signed'({1'b0, side_s1.bm});
		if (side_s2.bneg) begin
			p = -50'(pa_s2) + 50'(pb_s2);
		end else begin
			p = 50'(pa_s2) + 50'(pb_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_in;
			am_s1 <= am;

			side_s2 <= side_s1;
			am_s2 <= am_s1;
			asq_s2 <= am_s1 * am_s1;
			bsq_s2 <= side_s1.bm * side_s1.bm;
			pa_s2 <= side_s1.gx * am_sx;
			pb_s2 <= side_s1.gy * bm_sx;

			am_s3 <= am_s2;
			bm_s3 <= side_s2.bm;
			rad_s3 <= asq_s2 + 64'(bsq_s2);
			flags_s3.bneg <= side_s2.bneg;
			flags_s3.pneg <= p[49];
			flags_s3.pzero <= (p == 50'sd0);
			flags_s3.diag <= side_s2.diag;
			flags_s3.dx <= side_s2.dx;
			flags_s3.dy <= side_s2.dy;
		end
	end

	assign out_valid = v_s3;
	assign rad = rad_s3;
	assign side_out.am = am_s3;
	assign side_out.bm = bm_s3;
	assign side_out.flags = flags_s3;

endmodule

// File: hdl/stei_div.sv
module stei_div #(
	parameter int SIDE_W = 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [stei_pkg::AM_W-1:0] am,
	input logic [stei_pkg::NORM_BITS-1:0] bm,
	input logic [stei_pkg::ROOT2_N-1:0] r,
	input logic [SIDE_W-1:0] side_in,
	output logic out_valid,
	output logic [stei_pkg::QUO_W-1:0] qa,
	output logic [stei_pkg::QUO_W-1:0] qb,
	output logic [SIDE_W-1:0] side_out
);
	import stei_pkg::*;

	localparam int NUM_W = AM_W + QUO_W;

	logic v_s0;
	logic [NUM_W-1:0] na_s0, nb_s0;
	logic [ROOT2_N-1:0] r_s0;
	logic [SIDE_W-1:0] side_s0;

	logic [NUM_W-1:0] rema_s [QUO_W];
	logic [NUM_W-1:0] remb_s [QUO_W];
	logic [QUO_W-1:0] qa_s [QUO_W];
	logic [QUO_W-1:0] qb_s [QUO_W];
	logic [ROOT2_N-1:0] r_s [QUO_W];
	logic vld_s [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s0 <= (NUM_W'(am) << Q_FRAC) + NUM_W'(r >> 1);
			nb_s0 <= (NUM_W'(bm) << Q_FRAC) + NUM_W'(r >> 1);
			r_s0 <= r;
			side_s0 <= side_in;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [NUM_W-1:0] cur_a;
		logic [NUM_W-1:0] cur_b;
		logic [QUO_W-1:0] cur_qa;
		logic [QUO_W-1:0] cur_qb;
		logic [ROOT2_N-1:0] cur_r;
		logic cur_vld;
		logic [SIDE_W-1:0] cur_side;
		logic [NUM_W-1:0] dv;

		if (k == 0) begin : g_first
			assign cur_a = na_s0;
			assign cur_b = nb_s0;
			assign cur_qa = '0;
			assign cur_qb = '0;
			assign cur_r = r_s0;
			assign cur_vld = v_s0;
			assign cur_side = side_s0;
		end else begin : g_next
			assign cur_a = rema_s[k-1];
			assign cur_b = remb_s[k-1];
			assign cur_qa = qa_s[k-1];
			assign cur_qb = qb_s[k-1];
			assign cur_r = r_s[k-1];
			assign cur_vld = vld_s[k-1];
			assign cur_side = side_s[k-1];
		end

		assign dv = NUM_W'(cur_r) << (QUO_W - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= cur_r;
				side_s[k] <= cur_side;
				if (cur_a >= dv) begin
					rema_s[k] <= cur_a - dv;
					qa_s[k] <= {cur_qa[QUO_W-2:0], 1'b1};
				end else begin
					rema_s[k] <= cur_a;
					qa_s[k] <= {cur_qa[QUO_W-2:0], 1'b0};
				end
				if (cur_b >= dv) begin
					remb_s[k] <= cur_b - dv;
					qb_s[k] <= {cur_qb[QUO_W-2:0], 1'b1};
				end else begin
					remb_s[k] <= cur_b;
					qb_s[k] <= {cur_qb[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign qa = qa_s[QUO_W-1];
	assign qb = qb_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (qa <= QUO_W'(16384) && qb <= QUO_W'(16384)))
		else $error("Quotient exceeds one.");

endmodule

// File: hdl/structure_tensor_eigenvector_top.sv
// Channel  Role    Beat
// pixel    sink    grad_x, grad_y, tensor_xx, tensor_yy, tensor_xy
// eig      source  dir_x, dir_y
//
// One beat is accepted every cycle while the eig output is not stalled; the path
// runs through the two bit-serial square root pipelines (31 and 32 stages) and the 15-stage divider.
// Reset clears every valid bit of the pipeline; the payload registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module structure_tensor_eigenvector_top (
	input logic clk,
	input logic arst_n,
	stei_pix_if.sink pixel,
	stei_dir_if.source eig
);
	import stei_pkg::*;

	logic en;
	logic front_valid;
	logic [2*ROOT1_N-1:0] rad1;
	front_side_t front_side;
	logic root1_valid;
	logic [ROOT1_N-1:0] root1;
	logic [$bits(front_side_t)-1:0] root1_side;
	logic mid_valid;
	logic [2*ROOT2_N-1:0] rad2;
	root_side_t mid_side;
	logic root2_valid;
	logic [ROOT2_N-1:0] root2;
	logic [$bits(root_side_t)-1:0] root2_side_v;
	root_side_t root2_side;
	logic div_valid;
	logic [QUO_W-1:0] qa;
	logic [QUO_W-1:0] qb;
	logic [$bits(out_side_t)-1:0] div_side_v;
	out_side_t div_side;
	logic signed [15:0] vx;
	logic signed [15:0] vy;

	assign en = !div_valid || eig.ready;
	assign pixel.ready = en;

	stei_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(pixel.valid),
		.grad_x(pixel.grad_x),
		.grad_y(pixel.grad_y),
		.tensor_xx(pixel.tensor_xx),
		.tensor_yy(pixel.tensor_yy),
		.tensor_xy(pixel.tensor_xy),
		.out_valid(front_valid),
		.rad(rad1),
		.side(front_side)
	);

	stei_isqrt #(.N(ROOT1_N), .SIDE_W($bits(front_side_t))) u_root1 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(front_valid),
		.rad(rad1),
		.side_in(front_side),
		.out_valid(root1_valid),
		.root(root1),
		.side_out(root1_side)
	);

	stei_mid u_mid (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(root1_valid),
		.s(root1),
		.side_in(front_side_t'(root1_side)),
		.out_valid(mid_valid),
		.rad(rad2),
		.side_out(mid_side)
	);

	stei_isqrt #(.N(ROOT2_N), .SIDE_W($bits(root_side_t))) u_root2 (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(mid_valid),
		.rad(rad2),
		.side_in(mid_side),
		.out_valid(root2_valid),
		.root(root2),
		.side_out(root2_side_v)
	);

	assign root2_side = root_side_t'(root2_side_v);

	stei_div #(.SIDE_W($bits(out_side_t))) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(root2_valid),
		.am(root2_side.am),
		.bm(root2_side.bm),
		.r(root2),
		.side_in(root2_side.flags),
		.out_valid(div_valid),
		.qa(qa),
		.qb(qb),
		.side_out(div_side_v)
	);

	assign div_side = out_side_t'(div_side_v);

	always_comb begin
		vx = div_side.bneg ? -signed'({1'b0, qa}) : signed'({1'b0, qa});
		vy = signed'({1'b0, qb});
		if (div_side.diag) begin
			vx = div_side.dx;
			vy = div_side.dy;
		end else if (div_side.pzero) begin
			vx = 16'sd0;
			vy = 16'sd0;
		end else if (div_side.pneg) begin
			vx = -vx;
			vy = -vy;
		end
	end

	assign eig.valid = div_valid;
	assign eig.dir_x = vx;
	assign eig.dir_y = vy;

	assert property (@(posedge clk) disable iff (!arst_n)
		eig.valid |-> (vx <= Q_ONE && vx >= -Q_ONE && vy <= Q_ONE && vy >= -Q_ONE))
		else $error("Direction component out of range.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(eig.valid && div_side.diag) |-> (vx == 16'sd0 || vy == 16'sd0))
		else $error("Diagonal tensor gave a non-axis direction.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(eig.valid && !div_side.diag && !div_side.pzero) |-> (vx != 16'sd0 || vy != 16'sd0))
		else $error("Off-diagonal tensor gave a zero direction.");

endmodule
